/* design/spset_pkg.sv */
// Types shared by the sorted position set and its storage cells.
package spset_pkg;

    // Width of the element count carried on the result word.
    localparam int unsigned COUNT_OUT_BITS = 5;

    // Control broadcast from the top level to every cell in the chain.
    typedef struct packed {
        logic insert_new;   // accepted insert of a new position into a set with room
    } spset_ctrl_t;

endpackage

/* design/spset_cell.sv */
// One storage cell of the sorted chain. It compares its value against the
// broadcast position and, on an insert, either keeps its value, takes the new
// position, or takes the value of its lower neighbor (shift up by one cell).
module spset_cell #(
    parameter int unsigned POSITION_BITS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  spset_pkg::spset_ctrl_t   ctrl,
    input  logic [POSITION_BITS-1:0] position,
    input  logic [POSITION_BITS-1:0] prev_value,
    input  logic                     prev_valid,
    input  logic                     prev_less,
    output logic [POSITION_BITS-1:0] value,
    output logic                     valid,
    output logic                     less,
    output logic                     equal
);

    logic [POSITION_BITS-1:0] value_reg;
    logic [POSITION_BITS-1:0] value_next;
    logic                     valid_reg;
    logic                     valid_next;

    // Compare the held value against the broadcast position.
    assign less  = valid_reg && (value_reg < position);
    assign equal = valid_reg && (value_reg == position);

    // Choose what this cell holds after an insert.
    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctrl.insert_new && !less)
        begin
            if (prev_less)
            begin
                value_next = position;
                valid_next = 1'b1;
            end
            else
            begin
                value_next = prev_value;
                valid_next = prev_valid;
            end
        end
    end

    // The valid flag is control state; the value needs no reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign valid = valid_reg;

endmodule

/* design/sorted_position_set.sv */
// Sorted position set: holds up to CAPACITY distinct positions in ascending
// order in a chain of storage cells.
// Input channel (in_valid / in_ready) carries one word: op (0 = membership
// query, 1 = insert) and position. Output channel (out_valid / out_ready)
// carries one result word per input word: found, stored, overflow and the
// element count after the item.
// Every cell compares its value with the incoming position in parallel; an
// insert of a new position shifts the larger values up one cell and writes
// the new one into the gap, all in the cycle the word is accepted.
// The result is registered: it appears in the output register on the
// clock edge that accepts the word. Throughput is one word per cycle when
// the receiver is not stalling, set by the single compare-and-shift pass.
// When the receiver stalls, the result waits in the output register and the
// input stays ready only while that register is being emptied in the same
// cycle. Inserts into a full set are dropped and flagged as overflow.
// Reset empties the set (count zero, all cells invalid) and clears the
// output valid flag; no clearing pass is needed.
module sorted_position_set #(
    parameter int unsigned CAPACITY      = 16,
    parameter int unsigned POSITION_BITS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     op,
    input  logic [POSITION_BITS-1:0] position,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     found,
    output logic                     stored,
    output logic                     overflow,
    output logic [spset_pkg::COUNT_OUT_BITS-1:0] element_count
);

    localparam int unsigned COUNT_BITS = $clog2(CAPACITY + 1);

    logic [POSITION_BITS-1:0] cell_value [CAPACITY];
    logic [CAPACITY-1:0]      cell_valid;
    logic [CAPACITY-1:0]      cell_less;
    logic [CAPACITY-1:0]      cell_equal;

    logic [COUNT_BITS-1:0]    count_reg;
    logic [COUNT_BITS-1:0]    count_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic                     found_reg;
    logic                     stored_reg;
    logic                     overflow_reg;
    logic [spset_pkg::COUNT_OUT_BITS-1:0] count_out_reg;

    logic                     accept;
    logic                     hit;
    logic                     full;
    logic                     is_new;
    spset_pkg::spset_ctrl_t   ctrl;

    // Handshake: take a word whenever the output register is free or emptying.
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // Membership and room checks across the chain.
    assign hit    = |cell_equal;
    assign full   = cell_valid[CAPACITY-1];
    assign is_new = op && !hit;
    assign ctrl.insert_new = accept && is_new && !full;

    // Chain of cells; cell 0 has no lower neighbor, so it sees "less" as true.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        if (i == 0)
        begin : g_first
            spset_cell #(
                .POSITION_BITS(POSITION_BITS)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .position  (position),
                .prev_value(position),
                .prev_valid(1'b0),
                .prev_less (1'b1),
                .value     (cell_value[i]),
                .valid     (cell_valid[i]),
                .less      (cell_less[i]),
                .equal     (cell_equal[i])
            );
        end
        else
        begin : g_next
            spset_cell #(
                .POSITION_BITS(POSITION_BITS)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .position  (position),
                .prev_value(cell_value[i-1]),
                .prev_valid(cell_valid[i-1]),
                .prev_less (cell_less[i-1]),
                .value     (cell_value[i]),
                .valid     (cell_valid[i]),
                .less      (cell_less[i]),
                .equal     (cell_equal[i])
            );
        end
    end

    // Element count follows every stored insert.
    always_comb
    begin
        count_next = count_reg;
        if (ctrl.insert_new)
        begin
            count_next = count_reg + COUNT_BITS'(1);
        end
    end

    // Output register valid: set on accept, cleared when the word is taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload is loaded with each accepted word.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            found_reg     <= hit;
            stored_reg    <= is_new && !full;
            overflow_reg  <= is_new && full;
            count_out_reg <= spset_pkg::COUNT_OUT_BITS'(count_next);
        end
    end

    assign out_valid     = out_valid_reg;
    assign found         = found_reg;
    assign stored        = stored_reg;
    assign overflow      = overflow_reg;
    assign element_count = count_out_reg;

endmodule
